FILE: src/kmeans_2d_clustering_assert.svh
// Assertion macros for the k-means clustering block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef KMEANS_2D_CLUSTERING_ASSERT_SVH
`define KMEANS_2D_CLUSTERING_ASSERT_SVH

// Same-cycle implication.
`define KM2D_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KM2D_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/km2d_pkg.sv
// ----------------------------------------------------------------------------
// km2d_pkg
// Shared types, codes and helpers of the 2-D k-means clustering block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package km2d_pkg;

  // input operations
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // result status
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_NO_POINTS = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // result kind
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // register indexes
  localparam logic [1:0] REG_CLUSTERS  = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_MAX_ITER  = 2'd2;
  localparam logic [1:0] REG_SEED      = 2'd3;

  localparam int PADDR_W   = 4;
  localparam int IDX_W     = 10;
  localparam int INERTIA_W = 44;
  localparam int LFSR_W    = 16;
  localparam int ITER_W    = 8;

  localparam logic [3:0]        CLUSTERS_RST = 4'd3;
  localparam logic [31:0]       TOL_RST      = 32'd1;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 8'd100;
  localparam logic [LFSR_W-1:0] SEED_RST     = 16'd1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_QUERY,
    S_EMPTY,
    S_SEED_DIV,
    S_SEED_WAIT,
    S_SEED_WR,
    S_ITER_CLR,
    S_ASG_RD,
    S_ASG_DIST,
    S_ASG_WAIT,
    S_ASG_ACC,
    S_UPD_DIVX,
    S_UPD_WX,
    S_UPD_WY,
    S_UPD_SHIFT,
    S_UPD_SWAIT,
    S_CONV,
    S_INR_RD,
    S_INR_DIST,
    S_INR_WAIT,
    S_EMIT
  } km2d_state_e;

  // Fibonacci LFSR, taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
    logic fb;
    fb = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {fb, l[LFSR_W-1:1]};
  endfunction

endpackage

`default_nettype wire

FILE: src/km2d_ram.sv
// ----------------------------------------------------------------------------
// km2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module km2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/km2d_div.sv
// ----------------------------------------------------------------------------
// km2d_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module km2d_div #(
  parameter int DVW = 27,
  parameter int DSW = 11
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [DSW-1:0] divisor_i,
  output logic                done_o,
  output logic      [DVW-1:0] quot_o,
  output logic      [DSW-1:0] rem_o
);

  localparam int CW = $clog2(DVW + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [DVW-1:0] quot_q, quot_d;
  logic [DSW:0]   rem_q, rem_d;
  logic [DSW-1:0] dsr_q, dsr_d;
  logic [DSW:0]   rem_sh;
  logic           take;

  assign rem_sh = {rem_q[DSW-1:0], quot_q[DVW-1]};
  assign take   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVW);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = take ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quot_d = {quot_q[DVW-2:0], take};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quot_q <= quot_d;
      rem_q  <= rem_d;
      dsr_q  <= dsr_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[DSW-1:0];

endmodule

`default_nettype wire

FILE: src/km2d_sqdist.sv
// ----------------------------------------------------------------------------
// km2d_sqdist
// Two-stage squared Euclidean distance: squares, then their sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module km2d_sqdist #(
  parameter int CW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [CW-1:0] ax_i,
  input  wire logic signed [CW-1:0] ay_i,
  input  wire logic signed [CW-1:0] bx_i,
  input  wire logic signed [CW-1:0] by_i,
  output logic                      valid_o,
  output logic        [2*CW+1:0]    dist_o
);

  logic signed [CW:0]     dx, dy;
  logic signed [2*CW+1:0] sqx, sqy;
  logic [2*CW+1:0]        sqx_q, sqy_q, dist_q;
  logic                   v1_q, v2_q;

  assign dx  = (CW+1)'(ax_i) - (CW+1)'(bx_i);
  assign dy  = (CW+1)'(ay_i) - (CW+1)'(by_i);
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= unsigned'(sqx);
    sqy_q  <= unsigned'(sqy);
    dist_q <= sqx_q + sqy_q;
  end

  assign valid_o = v2_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

FILE: src/kmeans_2d_clustering.sv
// ----------------------------------------------------------------------------
// kmeans_2d_clustering
// Lloyd k-means over 2-D Q8.8 points held in on-chip RAM, LFSR seeding.
// ----------------------------------------------------------------------------
// Load and clear: a new item every cycle, no result.
// Query: the label is read from its RAM, then the result is registered once the output is free.
// Run: seeding draws one center per cluster by division, then each iteration runs
//   an assignment pass and a center update (an empty cluster skips its divisions),
//   then an inertia pass, then k results; the divider is 27 bits wide by default.
// Reset: control and registers to defaults, LFSR to 1; point RAM undefined.
`timescale 1ns / 1ps
`default_nettype none

module kmeans_2d_clustering #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 8,
  parameter int COORD_WIDTH  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [km2d_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic signed [COORD_WIDTH-1:0] x_i,
  input  wire logic signed [COORD_WIDTH-1:0] y_i,
  input  wire logic [km2d_pkg::IDX_W-1:0]    index_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               kind_o,
  output logic [2:0]                         cluster_o,
  output logic signed [COORD_WIDTH-1:0]      center_x_o,
  output logic signed [COORD_WIDTH-1:0]      center_y_o,
  output logic [km2d_pkg::ITER_W-1:0]        iterations_o,
  output logic [1:0]                         status_o,
  output logic [km2d_pkg::INERTIA_W-1:0]     inertia_o,
  output logic [2:0]                         point_label_o,
  output logic                               last_o
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int CI_W   = $clog2(MAX_CLUSTERS);
  localparam int KW     = $clog2(MAX_CLUSTERS + 1);
  localparam int CKW    = (KW > 4) ? KW : 4;
  localparam int SUM_W  = COORD_WIDTH + CNT_W;
  localparam int DVW    = (SUM_W > km2d_pkg::LFSR_W) ? SUM_W : km2d_pkg::LFSR_W;
  localparam int DIST_W = 2 * COORD_WIDTH + 2;
  localparam int CMP_W  = (DIST_W > 32) ? DIST_W : 32;
  localparam int XW     = (km2d_pkg::IDX_W > CNT_W) ? km2d_pkg::IDX_W : CNT_W;
  localparam int IW     = km2d_pkg::INERTIA_W;

  // configuration registers
  logic [3:0]                  clusters_q;
  logic [31:0]                 tol_q;
  logic [km2d_pkg::ITER_W-1:0] max_iter_q;
  logic [km2d_pkg::LFSR_W-1:0] seed_q;
  logic                        cfg_wr;

  km2d_pkg::km2d_state_e state_q, state_d;

  logic [CI_W-1:0]             ci_q, ci_d;
  logic [AW-1:0]               pi_q, pi_d;
  logic [CNT_W-1:0]            total_q, total_d;
  logic [km2d_pkg::ITER_W-1:0] iter_q, iter_d;
  logic [1:0]                  status_q, status_d;
  logic [CI_W-1:0]             best_q, best_d;
  logic [DIST_W-1:0]           bd_q, bd_d;
  logic [DIST_W-1:0]           maxsh_q, maxsh_d;
  logic [IW-1:0]               inertia_q, inertia_d;
  logic signed [COORD_WIDTH-1:0] nx_q, nx_d, ny_q, ny_d;
  logic                        qbad_q, qbad_d;
  logic [km2d_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;

  logic signed [COORD_WIDTH-1:0] cx_q [MAX_CLUSTERS];
  logic signed [COORD_WIDTH-1:0] cy_q [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]       sx_q [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]       sy_q [MAX_CLUSTERS];
  logic [CNT_W-1:0]              cnt_q [MAX_CLUSTERS];

  logic                        c_we;
  logic signed [COORD_WIDTH-1:0] c_wx, c_wy;
  logic                        sum_clr, sum_acc;

  // memories
  logic                       pt_we, pt_re;
  logic [AW-1:0]              pt_waddr, pt_raddr;
  logic [2*COORD_WIDTH-1:0]   pt_wdata, pt_rdata;
  logic                       lb_we, lb_re;
  logic [AW-1:0]              lb_waddr, lb_raddr;
  logic [CI_W-1:0]            lb_wdata, lb_rdata;
  logic signed [COORD_WIDTH-1:0] px, py;

  // divider
  logic              div_start, div_done;
  logic [DVW-1:0]    div_dividend, div_quot;
  logic [CNT_W-1:0]  div_divisor, div_rem;

  // distance unit
  logic                          sq_valid, sq_done;
  logic signed [COORD_WIDTH-1:0] sq_ax, sq_ay, sq_bx, sq_by;
  logic [DIST_W-1:0]             sq_dist;

  // output register
  logic                        out_valid_q, out_load, out_free;
  logic                        o_kind_d;
  logic [2:0]                  o_cluster_d, o_label_d;
  logic signed [COORD_WIDTH-1:0] o_cx_d, o_cy_d;
  logic [km2d_pkg::ITER_W-1:0] o_iter_d;
  logic [1:0]                  o_status_d;
  logic [IW-1:0]               o_inertia_d;
  logic                        o_last_d;

  // helpers
  logic [KW-1:0]               k_eff;
  logic [km2d_pkg::ITER_W-1:0] lim_eff;
  logic                        ci_last, pi_last;
  logic [CI_W-1:0]             cidx;
  logic signed [SUM_W-1:0]     sel_sx, sel_sy;
  logic [SUM_W-1:0]            mag_x, mag_y;
  logic signed [COORD_WIDTH-1:0] q_c;
  logic [km2d_pkg::ITER_W-1:0] iter_inc;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clusters_q <= km2d_pkg::CLUSTERS_RST;
      tol_q      <= km2d_pkg::TOL_RST;
      max_iter_q <= km2d_pkg::MAX_ITER_RST;
      seed_q     <= km2d_pkg::SEED_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        km2d_pkg::REG_CLUSTERS:  clusters_q <= pwdata[3:0];
        km2d_pkg::REG_TOLERANCE: tol_q      <= pwdata;
        km2d_pkg::REG_MAX_ITER:  max_iter_q <= pwdata[km2d_pkg::ITER_W-1:0];
        km2d_pkg::REG_SEED:      seed_q     <= pwdata[km2d_pkg::LFSR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      km2d_pkg::REG_CLUSTERS:  prdata = 32'(clusters_q);
      km2d_pkg::REG_TOLERANCE: prdata = tol_q;
      km2d_pkg::REG_MAX_ITER:  prdata = 32'(max_iter_q);
      km2d_pkg::REG_SEED:      prdata = 32'(seed_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------- helpers
  always_comb begin
    if (clusters_q == 4'd0) begin
      k_eff = KW'(1);
    end else if (CKW'(clusters_q) > CKW'(MAX_CLUSTERS)) begin
      k_eff = KW'(MAX_CLUSTERS);
    end else begin
      k_eff = KW'(clusters_q);
    end
  end

  assign lim_eff  = (max_iter_q == '0) ? km2d_pkg::ITER_W'(1) : max_iter_q;
  assign ci_last  = ci_q == CI_W'(k_eff - KW'(1));
  assign pi_last  = pi_q == AW'(total_q - CNT_W'(1));
  assign iter_inc = iter_q + km2d_pkg::ITER_W'(1);

  assign px = signed'(pt_rdata[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign py = signed'(pt_rdata[COORD_WIDTH-1:0]);

  assign sel_sx = sx_q[ci_q];
  assign sel_sy = sy_q[ci_q];
  assign mag_x  = sel_sx[SUM_W-1] ? unsigned'(-sel_sx) : unsigned'(sel_sx);
  assign mag_y  = sel_sy[SUM_W-1] ? unsigned'(-sel_sy) : unsigned'(sel_sy);
  assign q_c    = signed'(COORD_WIDTH'(div_quot));

  // center read port: label-indexed during the inertia pass
  assign cidx = (state_q == km2d_pkg::S_INR_DIST) ? lb_rdata : ci_q;

  always_comb begin
    sq_valid = 1'b0;
    sq_ax    = px;
    sq_ay    = py;
    sq_bx    = cx_q[cidx];
    sq_by    = cy_q[cidx];
    case (state_q)
      km2d_pkg::S_ASG_DIST,
      km2d_pkg::S_INR_DIST: sq_valid = 1'b1;
      km2d_pkg::S_UPD_SHIFT: begin
        sq_valid = 1'b1;
        sq_ax    = cx_q[cidx];
        sq_ay    = cy_q[cidx];
        sq_bx    = nx_q;
        sq_by    = ny_q;
      end
      default: ;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == km2d_pkg::S_IDLE;

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_d   = state_q;
    ci_d      = ci_q;
    pi_d      = pi_q;
    total_d   = total_q;
    iter_d    = iter_q;
    status_d  = status_q;
    best_d    = best_q;
    bd_d      = bd_q;
    maxsh_d   = maxsh_q;
    inertia_d = inertia_q;
    nx_d      = nx_q;
    ny_d      = ny_q;
    qbad_d    = qbad_q;
    lfsr_d    = lfsr_q;

    pt_we    = 1'b0;
    pt_waddr = AW'(total_q);
    pt_wdata = {x_i, y_i};
    pt_re    = 1'b0;
    pt_raddr = pi_q;
    lb_we    = 1'b0;
    lb_waddr = pi_q;
    lb_wdata = best_q;
    lb_re    = 1'b0;
    lb_raddr = pi_q;

    div_start    = 1'b0;
    div_dividend = DVW'(mag_x);
    div_divisor  = total_q;

    c_we    = 1'b0;
    c_wx    = nx_q;
    c_wy    = ny_q;
    sum_clr = 1'b0;
    sum_acc = 1'b0;

    out_load    = 1'b0;
    o_kind_d    = km2d_pkg::KIND_RUN;
    o_cluster_d = '0;
    o_cx_d      = '0;
    o_cy_d      = '0;
    o_iter_d    = '0;
    o_status_d  = km2d_pkg::ST_CONVERGED;
    o_inertia_d = '0;
    o_label_d   = '0;
    o_last_d    = 1'b1;

    case (state_q)
      km2d_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            km2d_pkg::OP_LOAD: begin
              if (total_q < CNT_W'(MAX_POINTS)) begin
                pt_we    = 1'b1;
                lb_we    = 1'b1;
                lb_waddr = AW'(total_q);
                lb_wdata = '0;
                total_d  = total_q + CNT_W'(1);
              end
            end
            km2d_pkg::OP_RUN: begin
              ci_d    = '0;
              state_d = (total_q == '0) ? km2d_pkg::S_EMPTY : km2d_pkg::S_SEED_DIV;
            end
            km2d_pkg::OP_QUERY: begin
              qbad_d   = XW'(index_i) >= XW'(total_q);
              lb_re    = 1'b1;
              lb_raddr = AW'(index_i);
              state_d  = km2d_pkg::S_QUERY;
            end
            km2d_pkg::OP_CLEAR: total_d = '0;
            default: ;
          endcase
        end
      end

      km2d_pkg::S_QUERY: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_kind_d   = km2d_pkg::KIND_QUERY;
          o_status_d = qbad_q ? km2d_pkg::ST_BAD_INDEX : km2d_pkg::ST_CONVERGED;
          o_label_d  = qbad_q ? 3'd0 : 3'(lb_rdata);
          state_d    = km2d_pkg::S_IDLE;
        end
      end

      km2d_pkg::S_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_status_d = km2d_pkg::ST_NO_POINTS;
          state_d    = km2d_pkg::S_IDLE;
        end
      end

      // initial centers: point at lfsr mod point count
      km2d_pkg::S_SEED_DIV: begin
        lfsr_d       = km2d_pkg::lfsr_next(lfsr_q);
        div_start    = 1'b1;
        div_dividend = DVW'(km2d_pkg::lfsr_next(lfsr_q));
        div_divisor  = total_q;
        state_d      = km2d_pkg::S_SEED_WAIT;
      end

      km2d_pkg::S_SEED_WAIT: begin
        if (div_done) begin
          pt_re    = 1'b1;
          pt_raddr = AW'(div_rem);
          state_d  = km2d_pkg::S_SEED_WR;
        end
      end

      km2d_pkg::S_SEED_WR: begin
        c_we = 1'b1;
        c_wx = px;
        c_wy = py;
        if (ci_last) begin
          iter_d  = '0;
          state_d = km2d_pkg::S_ITER_CLR;
        end else begin
          ci_d    = ci_q + CI_W'(1);
          state_d = km2d_pkg::S_SEED_DIV;
        end
      end

      km2d_pkg::S_ITER_CLR: begin
        sum_clr = 1'b1;
        pi_d    = '0;
        state_d = km2d_pkg::S_ASG_RD;
      end

      // assignment pass
      km2d_pkg::S_ASG_RD: begin
        pt_re   = 1'b1;
        ci_d    = '0;
        state_d = km2d_pkg::S_ASG_DIST;
      end

      km2d_pkg::S_ASG_DIST: state_d = km2d_pkg::S_ASG_WAIT;

      km2d_pkg::S_ASG_WAIT: begin
        if (sq_done) begin
          // strict compare keeps the lowest index on a tie
          if (ci_q == '0 || sq_dist < bd_q) begin
            bd_d   = sq_dist;
            best_d = ci_q;
          end
          if (ci_last) begin
            state_d = km2d_pkg::S_ASG_ACC;
          end else begin
            ci_d    = ci_q + CI_W'(1);
            state_d = km2d_pkg::S_ASG_DIST;
          end
        end
      end

      km2d_pkg::S_ASG_ACC: begin
        lb_we   = 1'b1;
        sum_acc = 1'b1;
        if (pi_last) begin
          ci_d    = '0;
          maxsh_d = '0;
          state_d = km2d_pkg::S_UPD_DIVX;
        end else begin
          pi_d    = pi_q + AW'(1);
          state_d = km2d_pkg::S_ASG_RD;
        end
      end

      // center update
      km2d_pkg::S_UPD_DIVX: begin
        if (cnt_q[ci_q] == '0) begin
          nx_d    = '0;
          ny_d    = '0;
          state_d = km2d_pkg::S_UPD_SHIFT;
        end else begin
          div_start    = 1'b1;
          div_dividend = DVW'(mag_x);
          div_divisor  = cnt_q[ci_q];
          state_d      = km2d_pkg::S_UPD_WX;
        end
      end

      km2d_pkg::S_UPD_WX: begin
        if (div_done) begin
          nx_d         = sel_sx[SUM_W-1] ? -q_c : q_c;
          div_start    = 1'b1;
          div_dividend = DVW'(mag_y);
          div_divisor  = cnt_q[ci_q];
          state_d      = km2d_pkg::S_UPD_WY;
        end
      end

      km2d_pkg::S_UPD_WY: begin
        if (div_done) begin
          ny_d    = sel_sy[SUM_W-1] ? -q_c : q_c;
          state_d = km2d_pkg::S_UPD_SHIFT;
        end
      end

      km2d_pkg::S_UPD_SHIFT: state_d = km2d_pkg::S_UPD_SWAIT;

      km2d_pkg::S_UPD_SWAIT: begin
        if (sq_done) begin
          if (sq_dist > maxsh_q) begin
            maxsh_d = sq_dist;
          end
          c_we = 1'b1;
          if (ci_last) begin
            state_d = km2d_pkg::S_CONV;
          end else begin
            ci_d    = ci_q + CI_W'(1);
            state_d = km2d_pkg::S_UPD_DIVX;
          end
        end
      end

      km2d_pkg::S_CONV: begin
        iter_d    = iter_inc;
        pi_d      = '0;
        inertia_d = '0;
        if (CMP_W'(maxsh_q) < CMP_W'(tol_q)) begin
          status_d = km2d_pkg::ST_CONVERGED;
          state_d  = km2d_pkg::S_INR_RD;
        end else if (iter_inc == lim_eff) begin
          status_d = km2d_pkg::ST_LIMIT;
          state_d  = km2d_pkg::S_INR_RD;
        end else begin
          state_d = km2d_pkg::S_ITER_CLR;
        end
      end

      // inertia pass
      km2d_pkg::S_INR_RD: begin
        pt_re   = 1'b1;
        lb_re   = 1'b1;
        state_d = km2d_pkg::S_INR_DIST;
      end

      km2d_pkg::S_INR_DIST: state_d = km2d_pkg::S_INR_WAIT;

      km2d_pkg::S_INR_WAIT: begin
        if (sq_done) begin
          inertia_d = inertia_q + IW'(sq_dist);
          if (pi_last) begin
            ci_d    = '0;
            state_d = km2d_pkg::S_EMIT;
          end else begin
            pi_d    = pi_q + AW'(1);
            state_d = km2d_pkg::S_INR_RD;
          end
        end
      end

      km2d_pkg::S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          o_cluster_d = 3'(ci_q);
          o_cx_d      = cx_q[ci_q];
          o_cy_d      = cy_q[ci_q];
          o_iter_d    = iter_q;
          o_status_d  = status_q;
          o_inertia_d = inertia_q;
          o_last_d    = ci_last;
          if (ci_last) begin
            state_d = km2d_pkg::S_IDLE;
          end else begin
            ci_d = ci_q + CI_W'(1);
          end
        end
      end

      default: state_d = km2d_pkg::S_IDLE;
    endcase

    // a seed write restarts the LFSR; zero acts as one
    if (cfg_wr && paddr[3:2] == km2d_pkg::REG_SEED) begin
      lfsr_d = (pwdata[km2d_pkg::LFSR_W-1:0] == '0) ? km2d_pkg::LFSR_W'(1)
                                                   : pwdata[km2d_pkg::LFSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= km2d_pkg::S_IDLE;
      ci_q        <= '0;
      pi_q        <= '0;
      total_q     <= '0;
      iter_q      <= '0;
      status_q    <= km2d_pkg::ST_CONVERGED;
      best_q      <= '0;
      bd_q        <= '0;
      maxsh_q     <= '0;
      inertia_q   <= '0;
      nx_q        <= '0;
      ny_q        <= '0;
      qbad_q      <= 1'b0;
      lfsr_q      <= km2d_pkg::SEED_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ci_q        <= ci_d;
      pi_q        <= pi_d;
      total_q     <= total_d;
      iter_q      <= iter_d;
      status_q    <= status_d;
      best_q      <= best_d;
      bd_q        <= bd_d;
      maxsh_q     <= maxsh_d;
      inertia_q   <= inertia_d;
      nx_q        <= nx_d;
      ny_q        <= ny_d;
      qbad_q      <= qbad_d;
      lfsr_q      <= lfsr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // centers and per-cluster accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cx_q[i]  <= '0;
        cy_q[i]  <= '0;
        sx_q[i]  <= '0;
        sy_q[i]  <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      if (c_we) begin
        cx_q[ci_q] <= c_wx;
        cy_q[ci_q] <= c_wy;
      end
      if (sum_clr) begin
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          sx_q[i]  <= '0;
          sy_q[i]  <= '0;
          cnt_q[i] <= '0;
        end
      end else if (sum_acc) begin
        sx_q[best_q]  <= sx_q[best_q] + SUM_W'(px);
        sy_q[best_q]  <= sy_q[best_q] + SUM_W'(py);
        cnt_q[best_q] <= cnt_q[best_q] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_o        <= o_kind_d;
      cluster_o     <= o_cluster_d;
      center_x_o    <= o_cx_d;
      center_y_o    <= o_cy_d;
      iterations_o  <= o_iter_d;
      status_o      <= o_status_d;
      inertia_o     <= o_inertia_d;
      point_label_o <= o_label_d;
      last_o        <= o_last_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ------------------------------------------------------------ instances
  km2d_ram #(
    .WIDTH (2 * COORD_WIDTH),
    .DEPTH (MAX_POINTS)
  ) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  km2d_ram #(
    .WIDTH (CI_W),
    .DEPTH (MAX_POINTS)
  ) u_lb_ram (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .re_i    (lb_re),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  km2d_div #(
    .DVW (DVW),
    .DSW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  km2d_sqdist #(
    .CW (COORD_WIDTH)
  ) u_sqdist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ax_i    (sq_ax),
    .ay_i    (sq_ay),
    .bx_i    (sq_bx),
    .by_i    (sq_by),
    .valid_o (sq_done),
    .dist_o  (sq_dist)
  );

endmodule

`default_nettype wire

FILE: src/km2d_chk.sv
// ----------------------------------------------------------------------------
// km2d_chk
// Port-level checks of the k-means clustering block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "kmeans_2d_clustering_assert.svh"

module km2d_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       kind_o,
  input wire logic [2:0] cluster_o,
  input wire logic [1:0] status_o,
  input wire logic [2:0] point_label_o,
  input wire logic       last_o
);

  `KM2D_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  `KM2D_ASSERT_IMPL(a_query_last, out_valid_o && kind_o == km2d_pkg::KIND_QUERY, last_o, "query answer without last")

  `KM2D_ASSERT_IMPL(a_bad_index, out_valid_o && status_o == km2d_pkg::ST_BAD_INDEX, kind_o == km2d_pkg::KIND_QUERY && point_label_o == 3'd0, "bad index answer malformed")

  `KM2D_ASSERT_IMPL(a_no_points, out_valid_o && status_o == km2d_pkg::ST_NO_POINTS, last_o && cluster_o == 3'd0, "empty run result malformed")

  `KM2D_ASSERT_IMPL(a_busy_mid_run, out_valid_o && !last_o, !in_ready_o, "input taken mid-run")

endmodule

bind kmeans_2d_clustering km2d_chk u_chk (.*);

`default_nettype wire
